// ===== design/i2cm_pkg.sv =====
// i2cm_pkg: shared types and constants for the I2C master transaction engine.
// No dependencies; imported by the interfaces and every module.
package i2cm_pkg;

   localparam int unsigned MAX_BYTES   = 256;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int unsigned CSR_INDEX_W = 4;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_CLOCK_DIVIDER = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_ACK_TIMEOUT   = CSR_INDEX_W'(1);

   localparam logic [15:0] DIVIDER_RESET = 16'd250;
   localparam logic [7:0]  TIMEOUT_RESET = 8'd100;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_ADDR_NACK = 2'd1,
      STATUS_DATA_NACK = 2'd2
   } status_type;

   typedef enum logic [4:0] {
      PH_IDLE      = 5'd0,
      PH_ST1       = 5'd1,
      PH_ST2       = 5'd2,
      PH_ST3       = 5'd3,
      PH_WB_LOW    = 5'd4,
      PH_WB_DATA   = 5'd5,
      PH_WB_HIGH   = 5'd6,
      PH_AK_REL    = 5'd7,
      PH_AK_SCL    = 5'd8,
      PH_AK_POLL   = 5'd9,
      PH_AK_LOW    = 5'd10,
      PH_NAK_LOW   = 5'd11,
      PH_WAIT_BYTE = 5'd12,
      PH_RB_LOW    = 5'd13,
      PH_RB_HIGH   = 5'd14,
      PH_KA_SET    = 5'd15,
      PH_KA_HIGH   = 5'd16,
      PH_KA_LOW    = 5'd17,
      PH_SP1       = 5'd18,
      PH_SP2       = 5'd19,
      PH_SP3       = 5'd20
   } phase_type;

   typedef struct packed {
      logic       start_request;
      logic       read_not_write;
      logic [6:0] target_address;
      logic [8:0] byte_count;
      logic [7:0] write_byte;
      logic       write_byte_valid;
      logic       sda_in;
   } req_item_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic [7:0] read_byte;
      logic       read_byte_valid;
      logic       need_write_byte;
      logic       busy_res;
      logic       done_res;
      logic [8:0] transferred_count;
      logic [1:0] status;
   } rsp_item_type;

   // front-to-back queue handshake
   typedef struct packed {
      logic         valid;
      req_item_type item;
   } queue_head_type;

endpackage

// ===== design/i2cm_req_if.sv =====
// i2cm_req_if: request channel (one bus tick per transaction).
// Depends on i2cm_pkg.
interface i2cm_req_if import i2cm_pkg::*;;
   logic         valid;
   logic         ready;
   req_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/i2cm_rsp_if.sv =====
// i2cm_rsp_if: response channel (pin levels and status per tick).
// Depends on i2cm_pkg.
interface i2cm_rsp_if import i2cm_pkg::*;;
   logic         valid;
   logic         ready;
   rsp_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/i2cm_csr_if.sv =====
// i2cm_csr_if: register write channel.
// Depends on i2cm_pkg.
interface i2cm_csr_if import i2cm_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ===== design/i2cm_front.sv =====
// i2cm_front: accepts request transactions into a short queue.
// Depends on i2cm_pkg and i2cm_req_if.
module i2cm_front import i2cm_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   i2cm_req_if.sink       req_if,
   output queue_head_type head,
   input  logic           pop
);

   req_item_type             entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                     push;

   function automatic logic [QUEUE_PTR_W-1:0] ptr_next(input logic [QUEUE_PTR_W-1:0] p);
      if (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1))
         return '0;
      else
         return p + QUEUE_PTR_W'(1);
   endfunction

   assign req_if.ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign push         = req_if.valid && req_if.ready;

   assign head.valid = (count_ff != '0);
   assign head.item  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop)
         count_in = count_ff + QUEUE_CNT_W'(1);
      else if (pop && !push)
         count_in = count_ff - QUEUE_CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         entries_ff[wr_ptr_ff] <= req_if.payload;
   end

endmodule

// ===== design/i2cm_engine.sv =====
// i2cm_engine: bus sequencer, registers and response output stage.
// Depends on i2cm_pkg, i2cm_rsp_if and i2cm_csr_if.
module i2cm_engine import i2cm_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   i2cm_csr_if.sink       csr_if,
   input  queue_head_type head,
   output logic           pop,
   i2cm_rsp_if.source     rsp_if
);

   // configuration
   logic [15:0] divider_ff;
   logic [7:0]  timeout_ff;
   logic [15:0] divider_eff;
   logic [7:0]  timeout_eff;

   // sequencer state
   phase_type  phase_ff, phase_in;
   logic [15:0] dly_ff, dly_in;
   logic [7:0]  ack_ff, ack_in;
   logic [3:0]  bit_ff, bit_in;
   logic [7:0]  shift_ff, shift_in;
   logic [8:0]  done_ff, done_in;
   logic [8:0]  want_ff, want_in;
   logic        dir_ff, dir_in;
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_in;
   status_type  stat_ff, stat_in;

   // response stage
   logic         rsp_valid_ff;
   rsp_item_type rsp_data_ff, rsp_data_in;

   logic         do_enter;
   phase_type    target;
   logic         rd_flag, dn_flag;
   req_item_type it;

   assign csr_if.ready = 1'b1;
   assign divider_eff  = (divider_ff == '0) ? 16'd1 : divider_ff;
   assign timeout_eff  = (timeout_ff == '0) ? 8'd1 : timeout_ff;

   assign pop = head.valid && (!rsp_valid_ff || rsp_if.ready);
   assign it  = head.item;

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

   always_comb begin
      phase_in = phase_ff;
      dly_in   = dly_ff;
      ack_in   = ack_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      done_in  = done_ff;
      want_in  = want_ff;
      dir_in   = dir_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      stat_in  = stat_ff;
      do_enter = 1'b0;
      target   = PH_IDLE;
      rd_flag  = 1'b0;
      dn_flag  = 1'b0;

      // tick: side effects first, phase entry below
      priority if (phase_ff == PH_IDLE) begin
         if (it.start_request) begin
            dir_in   = it.read_not_write;
            want_in  = (it.byte_count > 9'(MAX_BYTES)) ? 9'(MAX_BYTES) : it.byte_count;
            done_in  = '0;
            stat_in  = STATUS_ADDR_NACK;
            shift_in = {it.target_address, it.read_not_write};
            do_enter = 1'b1;
            target   = PH_ST1;
         end
      end else if (phase_ff == PH_WAIT_BYTE) begin
         if (it.write_byte_valid) begin
            shift_in = it.write_byte;
            bit_in   = '0;
            do_enter = 1'b1;
            target   = PH_WB_LOW;
         end
      end else if (phase_ff == PH_AK_POLL) begin
         if (!it.sda_in) begin
            do_enter = 1'b1;
            target   = PH_AK_LOW;
         end else begin
            ack_in = ack_ff + 8'd1;
            if (ack_in >= timeout_eff) begin
               do_enter = 1'b1;
               target   = PH_NAK_LOW;
            end
         end
      end else if (dly_ff > 16'd1) begin
         dly_in = dly_ff - 16'd1;
      end else begin
         do_enter = 1'b1;
         unique case (phase_ff)
            PH_ST1:     target = PH_ST2;
            PH_ST2:     target = PH_ST3;
            PH_ST3: begin
               bit_in = '0;
               target = PH_WB_LOW;
            end
            PH_WB_LOW:  target = PH_WB_DATA;
            PH_WB_DATA: target = PH_WB_HIGH;
            PH_WB_HIGH: begin
               bit_in   = bit_ff + 4'd1;
               shift_in = {shift_ff[6:0], 1'b0};
               target   = (bit_in < 4'd8) ? PH_WB_LOW : PH_AK_REL;
            end
            PH_AK_REL:  target = PH_AK_SCL;
            PH_AK_SCL:  target = PH_AK_POLL;
            PH_AK_LOW: begin
               if (stat_ff == STATUS_ADDR_NACK) begin
                  priority if (want_ff == '0) begin
                     stat_in = STATUS_OK;
                     target  = PH_SP1;
                  end else if (dir_ff) begin
                     stat_in  = STATUS_OK;
                     bit_in   = '0;
                     shift_in = '0;
                     target   = PH_RB_LOW;
                  end else begin
                     stat_in = STATUS_DATA_NACK;
                     target  = PH_WAIT_BYTE;
                  end
               end else begin
                  done_in = done_ff + 9'd1;
                  if (done_in >= want_ff) begin
                     stat_in = STATUS_OK;
                     target  = PH_SP1;
                  end else begin
                     target = PH_WAIT_BYTE;
                  end
               end
            end
            PH_NAK_LOW: target = PH_SP1;
            PH_RB_LOW:  target = PH_RB_HIGH;
            PH_RB_HIGH: begin
               shift_in = {shift_ff[6:0], it.sda_in};
               bit_in   = bit_ff + 4'd1;
               if (bit_in < 4'd8) begin
                  target = PH_RB_LOW;
               end else begin
                  rd_flag = 1'b1;
                  target  = PH_KA_SET;
               end
            end
            PH_KA_SET:  target = PH_KA_HIGH;
            PH_KA_HIGH: target = PH_KA_LOW;
            PH_KA_LOW: begin
               done_in = done_ff + 9'd1;
               if (done_in >= want_ff) begin
                  target = PH_SP1;
               end else begin
                  bit_in   = '0;
                  shift_in = '0;
                  target   = PH_RB_LOW;
               end
            end
            PH_SP1:     target = PH_SP2;
            PH_SP2:     target = PH_SP3;
            default: begin
               target  = PH_IDLE;
               dn_flag = 1'b1;
            end
         endcase
      end

      // phase entry: reload the delay unit and set the pin levels
      if (do_enter) begin
         phase_in = target;
         dly_in   = divider_eff;
         unique case (target)
            PH_ST1: begin
               scl_in = 1'b1;
               sda_in = 1'b1;
            end
            PH_ST2:     sda_in = 1'b0;
            PH_ST3:     scl_in = 1'b0;
            PH_WB_LOW:  scl_in = 1'b0;
            PH_WB_DATA: sda_in = shift_in[7];
            PH_WB_HIGH: scl_in = 1'b1;
            PH_AK_REL: begin
               scl_in = 1'b0;
               sda_in = 1'b1;
            end
            PH_AK_SCL:  scl_in = 1'b1;
            PH_AK_POLL: ack_in = '0;
            PH_AK_LOW:  scl_in = 1'b0;
            PH_NAK_LOW: scl_in = 1'b0;
            PH_RB_LOW: begin
               scl_in = 1'b0;
               sda_in = 1'b1;
            end
            PH_RB_HIGH: scl_in = 1'b1;
            PH_KA_SET: begin
               scl_in = 1'b0;
               // ACK unless this is the last byte
               sda_in = ({1'b0, done_in} + 10'd1 < {1'b0, want_in}) ? 1'b0 : 1'b1;
            end
            PH_KA_HIGH: scl_in = 1'b1;
            PH_KA_LOW:  scl_in = 1'b0;
            PH_SP1:     sda_in = 1'b0;
            PH_SP2:     scl_in = 1'b1;
            PH_SP3:     sda_in = 1'b1;
            // both lines released while the next write byte is awaited
            PH_WAIT_BYTE: begin
               scl_in = 1'b1;
               sda_in = 1'b1;
            end
            default: begin
               scl_in = 1'b1;
               sda_in = 1'b1;
               dly_in = '0;
            end
         endcase
      end

      rsp_data_in.scl_level         = scl_in;
      rsp_data_in.sda_level         = sda_in;
      rsp_data_in.read_byte         = rd_flag ? shift_in : 8'd0;
      rsp_data_in.read_byte_valid   = rd_flag;
      rsp_data_in.need_write_byte   = (phase_in == PH_WAIT_BYTE);
      rsp_data_in.busy_res          = (phase_in != PH_IDLE);
      rsp_data_in.done_res          = dn_flag;
      rsp_data_in.transferred_count = dn_flag ? done_in : 9'd0;
      rsp_data_in.status            = dn_flag ? stat_in : STATUS_OK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         divider_ff <= DIVIDER_RESET;
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_if.valid && csr_if.ready) begin
         if (csr_if.index == CSR_CLOCK_DIVIDER)
            divider_ff <= csr_if.wdata;
         else if (csr_if.index == CSR_ACK_TIMEOUT)
            timeout_ff <= csr_if.wdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         dly_ff   <= '0;
         ack_ff   <= '0;
         bit_ff   <= '0;
         shift_ff <= '0;
         done_ff  <= '0;
         want_ff  <= '0;
         dir_ff   <= 1'b0;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
         stat_ff  <= STATUS_OK;
      end else if (pop) begin
         phase_ff <= phase_in;
         dly_ff   <= dly_in;
         ack_ff   <= ack_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         done_ff  <= done_in;
         want_ff  <= want_in;
         dir_ff   <= dir_in;
         scl_ff   <= scl_in;
         sda_ff   <= sda_in;
         stat_ff  <= stat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (pop)
         rsp_valid_ff <= 1'b1;
      else if (rsp_if.ready)
         rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (pop)
         rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== design/i2c_master_transaction_engine.sv =====
// i2c_master_transaction_engine: top level of the I2C master sequencer.
// Depends on i2cm_pkg, the three channel interfaces, i2cm_front and i2cm_engine.
//
//  channel  | dir | carries                                        | transaction
//  ---------+-----+------------------------------------------------+------------------------
//  req_if   | in  | start, direction, address, count, write byte, SDA | one system tick
//  rsp_if   | out | SCL/SDA drive, read byte, need byte, busy, done  | one per request
//  csr_if   | in  | register index, write data                     | one register write
//
// Cycles: one request in and one response out per clock when both sides flow; a
//   request's response is registered in the queue and then in the output register
//   before it is presented.
// Reset: synchronous; phase idle, both pins released, divider 250, timeout 100.
// Stalls: a two-entry queue parts the request side from the sequencer, and the
//   output register holds a response until taken while the next request is queued.
// csr_if is always ready; writes are meant only while the engine is idle.
module i2c_master_transaction_engine import i2cm_pkg::*; (
   input logic        clock,
   input logic        reset,
   i2cm_req_if.sink   req_if,
   i2cm_rsp_if.source rsp_if,
   i2cm_csr_if.sink   csr_if
);

   queue_head_type head;
   logic           pop;

   // front: takes ticks into the queue
   i2cm_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .head   (head),
      .pop    (pop)
   );

   // back: phase machine, config registers, response register
   i2cm_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .head   (head),
      .pop    (pop),
      .rsp_if (rsp_if)
   );

endmodule

// ===== test/i2cm_checker.sv =====
// i2cm_checker: watches the request, response and register channels of the I2C
// master, forecasts every response tick and compares it field by field.
// Depends on i2cm_pkg and the three channel interfaces.
module i2cm_checker import i2cm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   i2cm_req_if         req_bus,
   i2cm_rsp_if         rsp_bus,
   i2cm_csr_if         csr_bus,
   output int unsigned mismatch_count,
   output int unsigned pending_count,
   output phase_type   engine_phase,
   output logic        addr_stage,
   output logic [8:0]  bytes_acked
);
   timeunit 1ns;
   timeprecision 1ps;

   // forecast copy of the sequencer
   logic [15:0] divider;
   logic [7:0]  ack_limit;
   phase_type   bus_phase;
   logic [15:0] unit_count;
   logic [7:0]  poll_count;
   logic [3:0]  bit_index;
   logic [7:0]  shifter;
   logic [8:0]  bytes_moved;
   logic [8:0]  bytes_asked;
   logic        reading;
   logic        scl_q;
   logic        sda_q;
   status_type  nack_code;
   logic        byte_ready;
   logic        stop_done;

   rsp_item_type tick_forecast[$];
   int unsigned  errors = 0;
   int unsigned  rsp_seen = 0;

   assign mismatch_count = errors;
   assign engine_phase   = bus_phase;
   assign addr_stage     = (nack_code == STATUS_ADDR_NACK);
   assign bytes_acked    = bytes_moved;

   task automatic reset_model();
      divider     = DIVIDER_RESET;
      ack_limit   = TIMEOUT_RESET;
      bus_phase   = PH_IDLE;
      unit_count  = '0;
      poll_count  = '0;
      bit_index   = '0;
      shifter     = '0;
      bytes_moved = '0;
      bytes_asked = '0;
      reading     = 1'b0;
      scl_q       = 1'b1;
      sda_q       = 1'b1;
      nack_code   = STATUS_OK;
   endtask

   task automatic enter_phase(input phase_type next);
      bus_phase  = next;
      unit_count = (divider != 16'd0) ? divider : 16'd1;
      case (next)
         PH_ST1: begin
            scl_q = 1'b1;
            sda_q = 1'b1;
         end
         PH_ST2, PH_SP1: sda_q = 1'b0;
         PH_ST3, PH_WB_LOW, PH_AK_LOW, PH_NAK_LOW, PH_KA_LOW: scl_q = 1'b0;
         PH_WB_DATA: sda_q = shifter[7];
         PH_WB_HIGH, PH_AK_SCL, PH_RB_HIGH, PH_KA_HIGH, PH_SP2: scl_q = 1'b1;
         PH_AK_REL, PH_RB_LOW: begin
            scl_q = 1'b0;
            sda_q = 1'b1;
         end
         PH_AK_POLL: poll_count = '0;
         PH_KA_SET: begin
            // ACK every byte but the last
            scl_q = 1'b0;
            sda_q = ({1'b0, bytes_moved} + 10'd1 < {1'b0, bytes_asked}) ? 1'b0 : 1'b1;
         end
         PH_SP3: sda_q = 1'b1;
         default: begin
            scl_q = 1'b1;
            sda_q = 1'b1;
         end
      endcase
   endtask

   task automatic start_read_byte();
      bit_index = '0;
      shifter   = '0;
      enter_phase(PH_RB_LOW);
   endtask

   // end of a timed step
   task automatic close_phase(input logic sda);
      case (bus_phase)
         PH_ST1:     enter_phase(PH_ST2);
         PH_ST2:     enter_phase(PH_ST3);
         PH_ST3: begin
            bit_index = '0;
            enter_phase(PH_WB_LOW);
         end
         PH_WB_LOW:  enter_phase(PH_WB_DATA);
         PH_WB_DATA: enter_phase(PH_WB_HIGH);
         PH_WB_HIGH: begin
            bit_index = bit_index + 4'd1;
            shifter   = shifter << 1;
            if (bit_index < 4'd8) enter_phase(PH_WB_LOW);
            else enter_phase(PH_AK_REL);
         end
         PH_AK_REL:  enter_phase(PH_AK_SCL);
         PH_AK_SCL:  enter_phase(PH_AK_POLL);
         PH_AK_LOW: begin
            if (nack_code == STATUS_ADDR_NACK) begin
               if (bytes_asked == 9'd0) begin
                  nack_code = STATUS_OK;
                  enter_phase(PH_SP1);
               end else if (reading) begin
                  nack_code = STATUS_OK;
                  start_read_byte();
               end else begin
                  nack_code = STATUS_DATA_NACK;
                  enter_phase(PH_WAIT_BYTE);
               end
            end else begin
               bytes_moved = bytes_moved + 9'd1;
               if (bytes_moved >= bytes_asked) begin
                  nack_code = STATUS_OK;
                  enter_phase(PH_SP1);
               end else begin
                  enter_phase(PH_WAIT_BYTE);
               end
            end
         end
         PH_NAK_LOW: enter_phase(PH_SP1);
         PH_RB_LOW:  enter_phase(PH_RB_HIGH);
         PH_RB_HIGH: begin
            shifter   = {shifter[6:0], sda};
            bit_index = bit_index + 4'd1;
            if (bit_index < 4'd8) begin
               enter_phase(PH_RB_LOW);
            end else begin
               byte_ready = 1'b1;
               enter_phase(PH_KA_SET);
            end
         end
         PH_KA_SET:  enter_phase(PH_KA_HIGH);
         PH_KA_HIGH: enter_phase(PH_KA_LOW);
         PH_KA_LOW: begin
            bytes_moved = bytes_moved + 9'd1;
            if (bytes_moved >= bytes_asked) enter_phase(PH_SP1);
            else start_read_byte();
         end
         PH_SP1:     enter_phase(PH_SP2);
         PH_SP2:     enter_phase(PH_SP3);
         default: begin
            enter_phase(PH_IDLE);
            unit_count = '0;
            stop_done  = 1'b1;
         end
      endcase
   endtask

   task automatic tick_engine(input req_item_type r, output rsp_item_type o);
      logic [7:0] limit;
      byte_ready = 1'b0;
      stop_done  = 1'b0;
      limit      = (ack_limit != 8'd0) ? ack_limit : 8'd1;
      if (bus_phase == PH_IDLE) begin
         if (r.start_request) begin
            reading     = r.read_not_write;
            bytes_asked = (r.byte_count > 9'(MAX_BYTES)) ? 9'(MAX_BYTES) : r.byte_count;
            bytes_moved = '0;
            nack_code   = STATUS_ADDR_NACK;
            shifter     = {r.target_address, r.read_not_write};
            enter_phase(PH_ST1);
         end
      end else if (bus_phase == PH_WAIT_BYTE) begin
         if (r.write_byte_valid) begin
            shifter   = r.write_byte;
            bit_index = '0;
            enter_phase(PH_WB_LOW);
         end
      end else if (bus_phase == PH_AK_POLL) begin
         if (!r.sda_in) begin
            enter_phase(PH_AK_LOW);
         end else begin
            poll_count = poll_count + 8'd1;
            if (poll_count >= limit) enter_phase(PH_NAK_LOW);
         end
      end else if (unit_count > 16'd1) begin
         unit_count = unit_count - 16'd1;
      end else begin
         close_phase(r.sda_in);
      end
      o                   = '0;
      o.scl_level         = scl_q;
      o.sda_level         = sda_q;
      o.read_byte         = byte_ready ? shifter : 8'd0;
      o.read_byte_valid   = byte_ready;
      o.need_write_byte   = (bus_phase == PH_WAIT_BYTE);
      o.busy_res          = (bus_phase != PH_IDLE);
      o.done_res          = stop_done;
      o.transferred_count = stop_done ? bytes_moved : 9'd0;
      o.status            = stop_done ? nack_code : STATUS_OK;
   endtask

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
         errors++;
         if (errors <= 10)
            $display("%0t: response %0d %s expected %0h got %0h",
                     $time, rsp_seen, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      rsp_item_type got;
      rsp_item_type next_tick;
      if (reset) begin
         reset_model();
         tick_forecast.delete();
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            if (csr_bus.index == CSR_CLOCK_DIVIDER) divider = csr_bus.wdata[15:0];
            else if (csr_bus.index == CSR_ACK_TIMEOUT) ack_limit = csr_bus.wdata[7:0];
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = rsp_bus.payload;
            if (tick_forecast.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: response %0d arrived with nothing outstanding",
                           $time, rsp_seen);
            end else begin
               want = tick_forecast.pop_front();
               compare_field("scl_level", want.scl_level, got.scl_level);
               compare_field("sda_level", want.sda_level, got.sda_level);
               compare_field("read_byte", want.read_byte, got.read_byte);
               compare_field("read_byte_valid", want.read_byte_valid, got.read_byte_valid);
               compare_field("need_write_byte", want.need_write_byte, got.need_write_byte);
               compare_field("busy_res", want.busy_res, got.busy_res);
               compare_field("done_res", want.done_res, got.done_res);
               compare_field("transferred_count", want.transferred_count,
                             got.transferred_count);
               compare_field("status", want.status, got.status);
            end
            rsp_seen++;
         end
         if (req_bus.valid && req_bus.ready) begin
            tick_engine(req_bus.payload, next_tick);
            tick_forecast.push_back(next_tick);
         end
      end
      pending_count = tick_forecast.size();
   end

endmodule

// ===== test/testbench.sv =====
// testbench: drives the I2C master with bus ticks from a reactive slave model and
// register writes, and gives the verdict from the checker's counts.
// Depends on i2cm_pkg, the channel interfaces, i2cm_checker and the engine RTL.
module testbench;
   import i2cm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // register indexes the engine does not decode; writes must be dropped
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_TOP_INDEX   = CSR_INDEX_W'(15);
   // no target for the forced NACK
   localparam int NO_NACK = -1;
   // random settings: divider and timeout per phase, small dividers dominate
   localparam int PLAN_LEN = 7;
   localparam int unsigned PHASE_TICKS = 40;

   logic clock;
   logic reset;

   i2cm_req_if req_if ();
   i2cm_rsp_if rsp_if ();
   i2cm_csr_if csr_if ();

   int unsigned mismatch_count;
   int unsigned pending_count;
   phase_type   engine_phase;
   logic        addr_stage;
   logic [8:0]  bytes_acked;

   int unsigned ticks_sent = 0;
   int          nack_target = NO_NACK;
   bit          calm = 1'b0;   // no gaps on either side while set

   int unsigned div_plan [PLAN_LEN] = '{1, 1, 2, 1, 0, 3, 1};
   int unsigned tmo_plan [PLAN_LEN] = '{1, 3, 2, 255, 0, 9, 40};

   i2c_master_transaction_engine DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   i2cm_checker bus_check (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_if),
      .rsp_bus        (rsp_if),
      .csr_bus        (csr_if),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .engine_phase   (engine_phase),
      .addr_stage     (addr_stage),
      .bytes_acked    (bytes_acked)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int unsigned gap_length();
      if ($urandom_range(0, 7) == 0) return $urandom_range(8, 30);
      return $urandom_range(1, 3);
   endfunction

   // write byte: the two extremes turn up often, otherwise anything
   function automatic logic [7:0] pick_write_byte();
      case ($urandom_range(0, 3))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // tick while no transfer runs: anything but a start, so it is ignored
   function automatic req_item_type idle_item();
      req_item_type item;
      item                  = req_item_type'($urandom);
      item.write_byte       = pick_write_byte();
      item.start_request    = 1'b0;
      return item;
   endfunction

   // tick while busy: a slave that ACKs after a short random lag, or holds SDA
   // high on the poll chosen for a NACK; read data and the rest are random
   function automatic req_item_type slave_item();
      req_item_type item;
      int           ack_index;
      item                  = req_item_type'($urandom);
      item.write_byte       = pick_write_byte();
      item.start_request    = ($urandom_range(0, 7) == 0);   // ignored while busy
      item.write_byte_valid = 1'($urandom_range(0, 1));
      if (engine_phase == PH_AK_POLL) begin
         ack_index = addr_stage ? 0 : int'(bytes_acked) + 1;
         if (ack_index == nack_target) item.sda_in = 1'b1;
         else item.sda_in = ($urandom_range(0, 3) == 0);
      end
      return item;
   endfunction

   // one request transaction; valid is left high so the next tick can follow
   // back to back
   task automatic send_tick(input req_item_type item);
      int unsigned gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = gap_length();
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= item;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      ticks_sent++;
      @(negedge clock);
   endtask

   // a whole bus transfer: a few ignored idle ticks, the start, then slave
   // ticks until the forecast says the STOP is done
   task automatic run_transfer(input logic rnw, input logic [6:0] addr,
                               input logic [8:0] count, input int nack_at);
      req_item_type item;
      calm        = ($urandom_range(0, 3) == 0);
      nack_target = nack_at;
      repeat ($urandom_range(0, 2)) send_tick(idle_item());
      item                = slave_item();
      item.start_request  = 1'b1;
      item.read_not_write = rnw;
      item.target_address = addr;
      item.byte_count     = count;
      send_tick(item);
      while (engine_phase != PH_IDLE) send_tick(slave_item());
   endtask

   task automatic random_transfer();
      logic [8:0] count;
      int         nack_at;
      int unsigned pick;
      count = ($urandom_range(0, 19) == 0) ? 9'($urandom_range(4, 12))
                                           : 9'($urandom_range(0, 3));
      pick  = $urandom_range(0, 5);
      if (pick == 0) nack_at = 0;
      else if (pick == 1 && count != 9'd0) nack_at = $urandom_range(1, int'(count));
      else nack_at = NO_NACK;
      run_transfer(1'($urandom_range(0, 1)), 7'($urandom), count, nack_at);
   endtask

   // drain every outstanding response, then a few clocks for the pipeline
   task automatic settle();
      req_if.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.wdata <= data;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      @(negedge clock);
      csr_if.valid <= 1'b0;
      @(negedge clock);
   endtask

   // timeout value with junk in the upper byte, which the engine must drop
   task automatic set_timing(input int unsigned div, input int unsigned tmo);
      csr_write(CSR_CLOCK_DIVIDER, CSR_DATA_W'(div));
      csr_write(CSR_ACK_TIMEOUT, {8'($urandom), 8'(tmo)});
   endtask

   // response side: ready stalls of random length, none while calm
   initial begin
      rsp_if.ready <= 1'b1;
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap_length()) @(negedge clock);
            rsp_if.ready <= 1'b1;
         end
      end
   end

   initial begin
      int unsigned phase_base;
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      csr_if.valid   <= 1'b0;
      csr_if.index   <= '0;
      csr_if.wdata   <= '0;
      reset          <= 1'b1;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset timing: idle ticks, then divider 1 with the reset timeout of 100
      repeat (4) send_tick(idle_item());
      settle();
      csr_write(CSR_CLOCK_DIVIDER, 16'd1);
      run_transfer(1'b0, 7'h5A, 9'd0, 0);         // address NACK after 100 polls
      settle();

      // largest divider and timeout: idle ticks only, as a transfer at these settings
      // would run far too long
      set_timing(16'hFFFF, 255);
      repeat (4) send_tick(idle_item());
      settle();
      // undecoded indexes must leave both registers alone
      csr_write(CSR_SPARE_INDEX, 16'h0003);
      csr_write(CSR_TOP_INDEX, 16'hFFFF);
      csr_write(CSR_CLOCK_DIVIDER, 16'd1);

      // divider 1 and longest timeout
      run_transfer(1'b0, 7'h55, 9'd2, 0);         // address NACK, full timeout
      settle();

      // directed transfers, divider 1 and a short timeout
      csr_write(CSR_ACK_TIMEOUT, 16'd12);
      run_transfer(1'b0, 7'h7F, 9'd1, NO_NACK);
      run_transfer(1'b0, 7'h00, 9'd3, NO_NACK);
      run_transfer(1'b1, 7'h7F, 9'd2, NO_NACK);
      run_transfer(1'b1, 7'h00, 9'd0, NO_NACK);   // read with zero count
      run_transfer(1'b1, 7'h2A, 9'd2, 0);         // address NACK on a read
      run_transfer(1'b0, 7'h33, 9'd4, 2);         // data NACK on second byte
      run_transfer(1'b0, 7'h4C, 9'h1FF, 3);       // oversized count cut short
      settle();

      // zero divider and zero timeout both act as one
      set_timing(0, 0);
      run_transfer(1'b1, 7'($urandom), 9'd1, NO_NACK);
      run_transfer(1'b0, 7'($urandom), 9'd3, 2);
      run_transfer(1'b0, 7'($urandom), 9'd2, NO_NACK);
      settle();

      // random transfers over a spread of settings
      for (int p = 0; p < PLAN_LEN; p++) begin
         set_timing(div_plan[p], tmo_plan[p]);
         phase_base = ticks_sent;
         while (ticks_sent - phase_base < PHASE_TICKS) random_transfer();
         settle();
      end

      for (int i = 0; i < 5000 && pending_count != 0; i++) @(negedge clock);
      repeat (8) @(negedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // hard stop, well beyond the slowest correct run
   initial begin
      #100ms;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== sim.f =====
design/i2cm_pkg.sv
design/i2cm_req_if.sv
design/i2cm_rsp_if.sv
design/i2cm_csr_if.sv
design/i2cm_front.sv
design/i2cm_engine.sv
design/i2c_master_transaction_engine.sv
test/i2cm_checker.sv
test/testbench.sv
